// ----- rtl/edd_pkg.sv -----
// Shared constants, types and a helper function for the edit distance engine.
package edd_pkg;

   localparam int MAX_REF_LEN  = 64;
   localparam int RefLenWidth  = $clog2(MAX_REF_LEN + 1);
   localparam int RefAddrWidth = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
   localparam int CharWidth    = 8;
   localparam int DistWidth    = 16;

   localparam logic [DistWidth-1:0] DIST_MAX = '1;

   typedef enum logic [1:0] {
      OP_CLEAR        = 2'd0,
      OP_REF_APPEND   = 2'd1,
      OP_QUERY_APPEND = 2'd2,
      OP_FINISH       = 2'd3
   } op_type;

   typedef struct packed {
      logic                    ref_wr;
      logic [RefAddrWidth-1:0] ref_wr_addr;
      logic                    rd_en;
      logic [RefAddrWidth-1:0] rd_addr;
      logic                    q_start;
      logic                    q_step;
      logic [RefAddrWidth-1:0] col_wr_addr;
      logic                    q_clear;
      logic                    ovf_set;
      logic                    ovf_clear;
      logic                    load_rsp;
      logic [RefLenWidth-1:0]  ref_len;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } sts_type;

   function automatic logic [DistWidth-1:0] sat_inc(input logic [DistWidth-1:0] v);
      return (v == DIST_MAX) ? v : v + DistWidth'(1);
   endfunction

endpackage

// ----- rtl/edd_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface edd_req_if;
   import edd_pkg::*;

   logic                 valid;
   logic                 ready;
   op_type               operation;
   logic [CharWidth-1:0] char_value;

   modport source (output valid, output operation, output char_value, input ready);
   modport sink (input valid, input operation, input char_value, output ready);
endinterface

interface edd_rsp_if;
   import edd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DistWidth-1:0] distance;
   logic                 reference_truncated;

   modport source (output valid, output distance, output reference_truncated, input ready);
   modport sink (input valid, input distance, input reference_truncated, output ready);
endinterface

// ----- rtl/edd_ctrl.sv -----
// Controller state machine that sequences reference updates and column sweeps.
module edd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  edd_pkg::op_type  req_op,
   input  edd_pkg::sts_type sts,
   output edd_pkg::cmd_type cmd
);
   import edd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   state_type              state_ff;
   logic [RefLenWidth-1:0] ref_len_ff;
   logic [RefLenWidth-1:0] idx_ff;
   logic [RefLenWidth-1:0] idx_plus;
   logic [RefLenWidth-1:0] last_idx;
   logic                   accept;
   logic                   ref_room;
   logic                   ref_empty;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign idx_plus  = idx_ff + RefLenWidth'(1);
   assign last_idx  = ref_len_ff - RefLenWidth'(1);
   assign ref_room  = (ref_len_ff < RefLenWidth'(MAX_REF_LEN));
   assign ref_empty = (ref_len_ff == '0);

   always_comb begin
      cmd             = '0;
      cmd.ref_len     = ref_len_ff;
      cmd.ref_wr_addr = ref_len_ff[RefAddrWidth-1:0];
      cmd.col_wr_addr = idx_ff[RefAddrWidth-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_CLEAR: begin
                     cmd.ovf_clear = 1'b1;
                     cmd.q_clear   = 1'b1;
                  end
                  OP_REF_APPEND: begin
                     if (ref_room) begin
                        cmd.ref_wr  = 1'b1;
                        cmd.q_clear = 1'b1;
                     end else begin
                        cmd.ovf_set = 1'b1;
                     end
                  end
                  OP_QUERY_APPEND: begin
                     cmd.q_start = 1'b1;
                     cmd.rd_en   = !ref_empty;
                     cmd.rd_addr = '0;
                  end
                  OP_FINISH: begin
                     cmd.rd_en   = !ref_empty;
                     cmd.rd_addr = last_idx[RefAddrWidth-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            cmd.q_step  = 1'b1;
            cmd.rd_en   = (idx_ff != last_idx);
            cmd.rd_addr = idx_plus[RefAddrWidth-1:0];
         end
         ST_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               cmd.q_clear  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ref_len_ff <= '0;
         idx_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_op)
                     OP_CLEAR: begin
                        ref_len_ff <= '0;
                     end
                     OP_REF_APPEND: begin
                        if (ref_room) begin
                           ref_len_ff <= ref_len_ff + RefLenWidth'(1);
                        end
                     end
                     OP_QUERY_APPEND: begin
                        idx_ff <= '0;
                        if (!ref_empty) begin
                           state_ff <= ST_RUN;
                        end
                     end
                     OP_FINISH: begin
                        state_ff <= ST_FIN;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RUN: begin
               idx_ff <= idx_plus;
               if (idx_ff == last_idx) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_FIN: begin
               if (!sts.rsp_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/edd_datapath.sv -----
// Datapath with the reference and column memories, the cell update and the result register.
module edd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [edd_pkg::CharWidth-1:0]   req_char,
   input  edd_pkg::cmd_type                cmd,
   output edd_pkg::sts_type                sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [edd_pkg::DistWidth-1:0]   rsp_distance,
   output logic                            rsp_truncated
);
   import edd_pkg::*;

   logic [CharWidth-1:0] ref_mem [MAX_REF_LEN];
   logic [DistWidth-1:0] col_mem [MAX_REF_LEN];

   logic [DistWidth-1:0] q_ff;
   logic                 ovf_ff;
   logic                 fresh_ff;
   logic [CharWidth-1:0] char_ff;
   logic [DistWidth-1:0] diag_ff;
   logic [DistWidth-1:0] left_ff;
   logic [DistWidth-1:0] col_rd_ff;
   logic [CharWidth-1:0] ref_rd_ff;
   logic                 rsp_valid_ff;
   logic [DistWidth-1:0] rsp_distance_ff;
   logic                 rsp_truncated_ff;

   logic [DistWidth-1:0] fresh_val;
   logic [DistWidth-1:0] old_val;
   logic [DistWidth:0]   diag_sum;
   logic [DistWidth-1:0] diag_val;
   logic [DistWidth-1:0] up_val;
   logic [DistWidth-1:0] left_val;
   logic [DistWidth-1:0] min_a;
   logic [DistWidth-1:0] new_val;
   logic [DistWidth-1:0] fin_val;

   assign fresh_val = DistWidth'(cmd.col_wr_addr) + DistWidth'(1);
   assign old_val   = fresh_ff ? fresh_val : col_rd_ff;
   assign diag_sum  = {1'b0, diag_ff} + {{DistWidth{1'b0}}, (ref_rd_ff != char_ff)};
   assign diag_val  = diag_sum[DistWidth] ? DIST_MAX : diag_sum[DistWidth-1:0];
   assign up_val    = sat_inc(old_val);
   assign left_val  = sat_inc(left_ff);
   assign min_a     = (up_val < left_val) ? up_val : left_val;
   assign new_val   = (min_a < diag_val) ? min_a : diag_val;

   always_comb begin
      if (q_ff == '0) begin
         fin_val = DistWidth'(cmd.ref_len);
      end else if (cmd.ref_len == '0) begin
         fin_val = q_ff;
      end else begin
         fin_val = col_rd_ff;
      end
   end

   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_truncated = rsp_truncated_ff;

   always_ff @(posedge clock) begin
      if (cmd.ref_wr) begin
         ref_mem[cmd.ref_wr_addr] <= req_char;
      end
      if (cmd.q_step) begin
         col_mem[cmd.col_wr_addr] <= new_val;
      end
      if (cmd.rd_en) begin
         col_rd_ff <= col_mem[cmd.rd_addr];
         ref_rd_ff <= ref_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         fresh_ff <= (q_ff == '0);
         char_ff  <= req_char;
         diag_ff  <= q_ff;
         left_ff  <= sat_inc(q_ff);
      end else if (cmd.q_step) begin
         diag_ff <= old_val;
         left_ff <= new_val;
      end
      if (cmd.load_rsp) begin
         rsp_distance_ff  <= fin_val;
         rsp_truncated_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.q_start) begin
            q_ff <= sat_inc(q_ff);
         end else if (cmd.q_clear) begin
            q_ff <= '0;
         end
         if (cmd.ovf_clear) begin
            ovf_ff <= 1'b0;
         end else if (cmd.ovf_set) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- rtl/edit_distance_engine.sv -----
// Top level of the edit distance engine: controller, datapath and channel hookup.
// Clear and reference append beats complete on acceptance and leave the controller idle.
// A query byte sweeps the column for a reference of n bytes: the column memory port
// updates one distance entry per cycle, one entry for each reference byte.
// A finish beat moves to the finish state, which loads the result register once the last result is taken;
// a result that still waits for the receiver holds the finish and stalls the input.
// Synchronous reset empties the reference and query and clears the flag; no clearing pass.
module edit_distance_engine (
   input logic       clock,
   input logic       reset,
   edd_req_if.sink   req_chan,
   edd_rsp_if.source rsp_chan
);
   import edd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   edd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_op    (req_chan.operation),
      .sts       (sts),
      .cmd       (cmd)
   );

   edd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_char      (req_chan.char_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_distance  (rsp_chan.distance),
      .rsp_truncated (rsp_chan.reference_truncated)
   );

endmodule
